// ===== rtl/core/klv_pkg.sv =====
// shared types, codes and constants of the klv ber stream framer
`timescale 1ns / 1ps
package klv_pkg;

  localparam int KEY_BYTES = 16;
  localparam int MAX_LENGTH_OCTETS_DEFAULT = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int PREFIX_BYTES = 4;
  localparam int CATEGORY_INDEX = 4;
  localparam logic [31:0] KEY_PREFIX_RESET = 32'h060E_2B34;

  typedef enum logic [1:0] {
    PH_KEY  = 2'd0,
    PH_LEN0 = 2'd1,
    PH_OCT  = 2'd2,
    PH_VAL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT_KEY = 3'd1,
    ERR_SHORT_LEN = 3'd2,
    ERR_SHORT_VAL = 3'd3,
    ERR_LONG_LEN  = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    phase_t      phase;
    logic [7:0]  registry_category;
    logic        prefix_ok;
    logic [31:0] value_length;
    logic        length_done;
    logic        item_end;
    err_t        error;
  } klv_result_t;

endpackage

// ===== rtl/core/klv_ber_stream_framer_unit.sv =====
// top level of the klv ber stream framer: parser front end and result queue
`timescale 1ns / 1ps
// a byte's result is built combinationally and written into the result queue at the edge that
//   accepts the byte; with the queue empty it shows on the outputs straight after that edge
// throughput: one byte per cycle while the queue is not full; full rises only when QUEUE_DEPTH results wait unpopped
// reset (rst, synchronous, active high): key phase, empty queue, key_prefix back to 0x060E2B34
module klv_ber_stream_framer_unit import klv_pkg::*; #(
  parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEFAULT,
  parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: key prefix
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input request side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        buffer_end,
  // result request side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic [1:0]  phase,
  output logic [7:0]  registry_category,
  output logic        prefix_ok,
  output logic [31:0] value_length,
  output logic        length_done,
  output logic        item_end,
  output logic [2:0]  error
);

  // a request is taken whenever there is room for its result
  logic        in_accept;
  logic        out_accept;
  klv_result_t parse_result;
  klv_result_t head;

  assign in_accept  = push && !full;
  assign out_accept = pop && !empty;

  // front end: phase tracking, prefix check, ber length decode
  klv_parse #(
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (in_accept),
    .in_byte    (in_byte),
    .buffer_end (buffer_end),
    .result     (parse_result)
  );

  // back end: results wait here so the two sides stall independently
  klv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (in_accept),
    .wr_data(parse_result),
    .rd_en  (out_accept),
    .rd_data(head),
    .full   (full),
    .empty  (empty)
  );

  // unpack the oldest result onto the ports
  assign out_byte          = head.out_byte;
  assign phase             = head.phase;
  assign registry_category = head.registry_category;
  assign prefix_ok         = head.prefix_ok;
  assign value_length      = head.value_length;
  assign length_done       = head.length_done;
  assign item_end          = head.item_end;
  assign error             = head.error;

  // a length is reported only on the byte that completes it
  a_len_zero_unless_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && !length_done) |-> (value_length == '0))
    else $error("value_length set without length_done");

  // key bytes never complete a length field
  a_key_no_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase == PH_KEY) |-> !length_done)
    else $error("length_done during key phase");

  // an item ending on a length octet must be a zero-length value
  a_oct_end_is_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && item_end && phase == PH_OCT) |-> length_done)
    else $error("item_end on length octet without length_done");

  // after reset the queue holds nothing
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("queue not empty after reset");

endmodule

// ===== rtl/core/klv_parse.sv =====
// front end: accepts stream bytes, tracks the klv phase and builds one result per byte
`timescale 1ns / 1ps
module klv_parse import klv_pkg::*; #(
  parameter int MAX_LENGTH_OCTETS = MAX_LENGTH_OCTETS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        buffer_end,
  output klv_result_t result
);

  logic [31:0] key_prefix;
  phase_t      phase_reg, phase_reg_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] length_acc, length_acc_next;
  logic [6:0]  octets_left, octets_left_next;
  logic        prefix_match, prefix_match_next;
  logic [7:0]  category_reg, category_reg_next;
  logic        too_many_octets, too_many_octets_next;

  logic        done, iend;
  logic [31:0] vlen;
  err_t        err;
  logic [7:0]  exp_byte;
  logic        byte_match;
  logic [6:0]  n_octets;

  // expected prefix byte, first byte in the top octet
  always_comb begin
    case (byte_count[1:0])
      2'd0:    exp_byte = key_prefix[31:24];
      2'd1:    exp_byte = key_prefix[23:16];
      2'd2:    exp_byte = key_prefix[15:8];
      default: exp_byte = key_prefix[7:0];
    endcase
  end

  assign byte_match = (exp_byte == in_byte);
  assign n_octets   = in_byte[6:0];

  always_comb begin
    phase_reg_next       = phase_reg;
    byte_count_next      = byte_count;
    length_acc_next      = length_acc;
    octets_left_next     = octets_left;
    prefix_match_next    = prefix_match;
    category_reg_next    = category_reg;
    too_many_octets_next = too_many_octets;
    done = 1'b0;
    iend = 1'b0;
    vlen = '0;
    err  = ERR_NONE;

    unique case (phase_reg)
      PH_KEY: begin
        if (byte_count < 32'(PREFIX_BYTES)) begin
          prefix_match_next = (byte_count == '0) ? byte_match : (prefix_match && byte_match);
        end
        if (byte_count == 32'(CATEGORY_INDEX)) begin
          category_reg_next = in_byte;
        end
        if (byte_count == 32'(KEY_BYTES - 1)) begin
          byte_count_next = '0;
          phase_reg_next  = PH_LEN0;
        end else begin
          byte_count_next = byte_count + 32'd1;
        end
      end
      PH_LEN0: begin
        if (!in_byte[7]) begin
          done = 1'b1;
          vlen = {24'd0, in_byte};
        end else begin
          too_many_octets_next = n_octets > 7'(MAX_LENGTH_OCTETS);
          length_acc_next      = '0;
          if (n_octets == '0) begin
            done = 1'b1;
          end else begin
            octets_left_next = n_octets;
            phase_reg_next   = PH_OCT;
          end
        end
      end
      PH_OCT: begin
        // only the last four octets survive the shift
        length_acc_next  = {length_acc[23:0], in_byte};
        octets_left_next = octets_left - 7'd1;
        if (octets_left_next == '0) begin
          done = 1'b1;
          vlen = length_acc_next;
        end
      end
      PH_VAL: begin
        byte_count_next = byte_count - 32'd1;
        if (byte_count_next == '0) begin
          iend = 1'b1;
        end
      end
    endcase

    if (done) begin
      if (too_many_octets_next) begin
        err = ERR_LONG_LEN;
      end
      if (vlen == '0) begin
        iend = 1'b1;
      end else begin
        byte_count_next = vlen;
        phase_reg_next  = PH_VAL;
      end
    end

    if (iend || buffer_end) begin
      if (!iend) begin
        case (phase_reg_next)
          PH_KEY:  err = ERR_SHORT_KEY;
          PH_VAL:  err = ERR_SHORT_VAL;
          default: err = ERR_SHORT_LEN;
        endcase
      end
      // fresh item
      phase_reg_next       = PH_KEY;
      byte_count_next      = '0;
      length_acc_next      = '0;
      octets_left_next     = '0;
      prefix_match_next    = 1'b1;
      too_many_octets_next = 1'b0;
    end
  end

  always_comb begin
    result.out_byte          = in_byte;
    result.phase             = phase_reg;
    result.registry_category = category_reg_next;
    result.prefix_ok         = prefix_match_next;
    result.value_length      = vlen;
    result.length_done       = done;
    result.item_end          = iend;
    result.error             = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_prefix      <= KEY_PREFIX_RESET;
      phase_reg       <= PH_KEY;
      byte_count      <= '0;
      length_acc      <= '0;
      octets_left     <= '0;
      prefix_match    <= 1'b1;
      category_reg    <= '0;
      too_many_octets <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_prefix <= cfg_wr_data;
      end
      if (accept) begin
        phase_reg       <= phase_reg_next;
        byte_count      <= byte_count_next;
        length_acc      <= length_acc_next;
        octets_left     <= octets_left_next;
        prefix_match    <= prefix_match_next;
        category_reg    <= category_reg_next;
        too_many_octets <= too_many_octets_next;
      end
    end
  end

endmodule

// ===== rtl/core/klv_queue.sv =====
// back end: short result queue with first-word fall-through
`timescale 1ns / 1ps
module klv_queue import klv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  klv_result_t wr_data,
  input  logic        rd_en,
  output klv_result_t rd_data,
  output logic        full,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  klv_result_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== bench/klv_ber_stream_framer_unit_tb.sv =====
// self-checking bench for the klv ber stream framer: byte stream framing, length decode, errors
`timescale 1ns / 1ps
import klv_pkg::*;

// tracks the framing state of the byte stream and holds the results still owed by the block
class klv_frame_tracker;
  logic [31:0] key_prefix;
  phase_t      phase_q;
  logic [31:0] count_q;
  logic [31:0] length_acc;
  logic [6:0]  octets_left;
  logic        prefix_match;
  logic [7:0]  category;
  logic        too_many;
  klv_result_t owed_results[$];
  int          mismatches;

  function new();
    key_prefix = KEY_PREFIX_RESET;
    category = 8'h00;
    mismatches = 0;
    restart_item();
  endfunction

  function void restart_item();
    phase_q = PH_KEY;
    count_q = 32'd0;
    length_acc = 32'd0;
    octets_left = 7'd0;
    prefix_match = 1'b1;
    too_many = 1'b0;
  endfunction

  function int waiting();
    return owed_results.size();
  endfunction

  // one accepted byte gives exactly one result
  function void note_request(input logic [7:0] b, input logic last);
    klv_result_t r;
    phase_t ph;
    logic done;
    logic iend;
    logic [31:0] vlen;
    logic [6:0] n;
    err_t err;
    logic [7:0] want;
    ph = phase_q;
    done = 1'b0;
    iend = 1'b0;
    vlen = 32'd0;
    err = ERR_NONE;
    case (ph)
      PH_KEY: begin
        if (count_q < PREFIX_BYTES) begin
          want = key_prefix[31 - 8 * count_q -: 8];
          prefix_match = (count_q == 0) ? (want == b) : (prefix_match && (want == b));
        end
        if (count_q == CATEGORY_INDEX) category = b;
        if (count_q + 1 >= KEY_BYTES) begin
          count_q = 32'd0;
          phase_q = PH_LEN0;
        end else begin
          count_q = count_q + 1;
        end
      end
      PH_LEN0: begin
        if (!b[7]) begin
          done = 1'b1;
          vlen = {24'd0, b};
        end else begin
          n = b[6:0];
          too_many = (n > MAX_LENGTH_OCTETS_DEFAULT);
          length_acc = 32'd0;
          if (n == 0) begin
            done = 1'b1;
          end else begin
            octets_left = n;
            phase_q = PH_OCT;
          end
        end
      end
      PH_OCT: begin
        length_acc = {length_acc[23:0], b};
        octets_left = octets_left - 7'd1;
        if (octets_left == 0) begin
          done = 1'b1;
          vlen = length_acc;
        end
      end
      default: begin
        count_q = count_q - 1;
        if (count_q == 0) iend = 1'b1;
      end
    endcase
    if (done) begin
      if (too_many) err = ERR_LONG_LEN;
      if (vlen == 0) begin
        iend = 1'b1;
      end else begin
        count_q = vlen;
        phase_q = PH_VAL;
      end
    end
    if (iend) begin
      restart_item();
    end else if (last) begin
      case (phase_q)
        PH_KEY:  err = ERR_SHORT_KEY;
        PH_VAL:  err = ERR_SHORT_VAL;
        default: err = ERR_SHORT_LEN;
      endcase
      restart_item();
    end
    r.out_byte = b;
    r.phase = ph;
    r.registry_category = category;
    r.prefix_ok = prefix_match;
    r.value_length = done ? vlen : 32'd0;
    r.length_done = done;
    r.item_end = iend;
    r.error = err;
    owed_results = {owed_results, r};
  endfunction

  function void check_result(input klv_result_t got);
    klv_result_t exp;
    string diff;
    if (owed_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result with nothing owed: byte=%h phase=%0d", got.out_byte, got.phase);
      return;
    end
    exp = owed_results.pop_front();
    diff = "";
    if (exp.out_byte !== got.out_byte) diff = {diff, " out_byte"};
    if (exp.phase !== got.phase) diff = {diff, " phase"};
    if (exp.registry_category !== got.registry_category) diff = {diff, " registry_category"};
    if (exp.prefix_ok !== got.prefix_ok) diff = {diff, " prefix_ok"};
    if (exp.value_length !== got.value_length) diff = {diff, " value_length"};
    if (exp.length_done !== got.length_done) diff = {diff, " length_done"};
    if (exp.item_end !== got.item_end) diff = {diff, " item_end"};
    if (exp.error !== got.error) diff = {diff, " error"};
    if (diff != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on%s", diff);
        $display("  expected byte=%h ph=%0d cat=%h pok=%b len=%h done=%b end=%b err=%0d",
                 exp.out_byte, exp.phase, exp.registry_category, exp.prefix_ok,
                 exp.value_length, exp.length_done, exp.item_end, exp.error);
        $display("  actual   byte=%h ph=%0d cat=%h pok=%b len=%h done=%b end=%b err=%0d",
                 got.out_byte, got.phase, got.registry_category, got.prefix_ok,
                 got.value_length, got.length_done, got.item_end, got.error);
      end
    end
  endfunction
endclass

module klv_ber_stream_framer_unit_tb;

  localparam int LIMIT = 200000;      // cycles, far beyond the slowest correct run
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int PHASE_BYTES = 25;    // random bytes per prefix setting

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        buffer_end;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic [1:0]  phase;
  logic [7:0]  registry_category;
  logic        prefix_ok;
  logic [31:0] value_length;
  logic        length_done;
  logic        item_end;
  logic [2:0]  error;

  klv_frame_tracker frames;
  logic [7:0] item_bytes[$];   // bytes of the item being built
  int  bytes_sent = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;         // random gaps on both sides
  bit  hold_req = 1'b0;        // asks the receiver for one long hold-off

  klv_ber_stream_framer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .buffer_end(buffer_end),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .phase(phase),
    .registry_category(registry_category),
    .prefix_ok(prefix_ok),
    .value_length(value_length),
    .length_done(length_done),
    .item_end(item_end),
    .error(error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one byte request; returns at the edge that took it
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    buffer_end <= last;
    // full is sampled mid-cycle, where it holds its value for the coming edge
    forever begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
      if (taken) break;
    end
    frames.note_request(b, last);
    bytes_sent++;
  endtask

  // key, ber length (short or long form) and nval value bytes
  task automatic add_item(input bit good_prefix, input bit long_form, input int nocts,
                          input logic [31:0] vlen, input int nval);
    int spoil;
    logic [7:0] pb;
    logic [7:0] ob;
    spoil = $urandom_range(0, PREFIX_BYTES - 1);
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < PREFIX_BYTES) begin
        pb = frames.key_prefix[31 - 8 * i -: 8];
        // a bad prefix keeps the other bytes right, so the match chain is exercised
        if (!good_prefix && i == spoil) pb = pb ^ 8'($urandom_range(1, 255));
        item_bytes = {item_bytes, pb};
      end else begin
        ob = 8'($urandom);
        item_bytes = {item_bytes, ob};
      end
    end
    if (!long_form) begin
      ob = {1'b0, vlen[6:0]};
      item_bytes = {item_bytes, ob};
    end else begin
      ob = {1'b1, 7'(nocts)};
      item_bytes = {item_bytes, ob};
      // big-endian; octets ahead of the last four are shifted out anyway
      for (int k = nocts - 1; k >= 0; k--) begin
        ob = (k < 4) ? vlen[8 * k +: 8] : 8'($urandom);
        item_bytes = {item_bytes, ob};
      end
    end
    for (int i = 0; i < nval; i++) begin
      ob = 8'($urandom);
      item_bytes = {item_bytes, ob};
    end
  endtask

  // cut >= 0 ends the buffer on that byte and drops the rest
  task automatic send_item(input int cut, input bit end_at_last);
    int n;
    n = (cut >= 0 && cut < item_bytes.size()) ? cut + 1 : item_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(item_bytes[i], (i == n - 1) && (cut >= 0 || end_at_last));
    item_bytes.delete();
  endtask

  task automatic random_item();
    int r;
    int nocts;
    int nval;
    int n;
    bit long_form;
    logic [31:0] vlen;
    r = $urandom_range(0, 99);
    long_form = $urandom_range(0, 1);
    if (r < 70) begin
      // well-formed item, small value
      nocts = $urandom_range(0, 6);
      vlen = (long_form && nocts == 0) ? 32'd0 : 32'($urandom_range(0, 8));
      add_item($urandom_range(0, 4) != 0, long_form, nocts, vlen, vlen);
      send_item(-1, $urandom_range(0, 3) == 0);
    end else if (r < 85) begin
      // item cut short somewhere, often with a huge length
      nocts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
      vlen = long_form ? $urandom : 32'($urandom_range(0, 127));
      nval = (vlen < 6) ? vlen : $urandom_range(0, 5);
      add_item($urandom_range(0, 1), long_form, nocts, vlen, nval);
      send_item($urandom_range(0, item_bytes.size() - 1), 1'b1);
    end else begin
      // raw noise, always closed by a buffer end so framing restarts
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
    end
  endtask

  // wait until every owed result has been popped
  task automatic drain();
    push <= 1'b0;
    while (frames.waiting() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // prefix is only written while the block is idle
  task automatic write_prefix(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frames.key_prefix = v;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        pop <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result is checked mid-cycle; it is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && pop && !empty)
      frames.check_result('{out_byte, phase_t'(phase), registry_category, prefix_ok,
                            value_length, length_done, item_end, err_t'(error)});
  end

  initial begin
    logic [31:0] prefixes[4];
    int goal;
    rst <= 1'b1;
    push <= 1'b0;
    in_byte <= 8'h00;
    buffer_end <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 32'h0;
    frames = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset prefix
    add_item(1, 0, 0, 3, 3);            send_item(-1, 0);
    add_item(1, 0, 0, 0, 0);            send_item(-1, 1);  // zero length, buffer ends on item end
    add_item(1, 1, 0, 0, 0);            send_item(-1, 0);  // long form with no octets
    add_item(1, 1, 2, 5, 5);            send_item(-1, 0);
    add_item(1, 1, 2, 0, 0);            send_item(-1, 0);  // octets decode to zero
    add_item(1, 1, 6, 2, 2);            send_item(-1, 0);  // more than four octets
    add_item(0, 0, 0, 1, 1);            send_item(-1, 0);  // prefix mismatch
    add_item(1, 0, 0, 127, 0);          send_item(7, 1);   // buffer ends inside the key
    add_item(1, 0, 0, 9, 0);            send_item(16, 1);  // ends on short length, value pending
    add_item(1, 1, 3, 20, 0);           send_item(16, 1);  // ends on long-form byte
    add_item(1, 1, 3, 20, 0);           send_item(18, 1);  // ends inside the octets
    add_item(1, 1, 5, 3, 0);            send_item(21, 1);  // over-long form, truncation code wins
    add_item(1, 0, 0, 10, 4);           send_item(19, 1);  // ends inside the value
    add_item(1, 1, 4, 32'hFFFF_FFFF, 2); send_item(22, 1); // largest length
    add_item(1, 1, 127, 1, 1);          send_item(-1, 0);  // longest octet run
    drain();

    prefixes[0] = 32'h0000_0000;
    prefixes[1] = 32'hFFFF_FFFF;
    prefixes[2] = $urandom;
    prefixes[3] = KEY_PREFIX_RESET;
    for (int p = 0; p < 4; p++) begin
      write_prefix(prefixes[p]);
      if (p == 0) hold_req = 1'b1;   // sender keeps going until full stalls it
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        idle_on = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
        random_item();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (frames.mismatches == 0 && frames.waiting() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/klv_pkg.sv
rtl/core/klv_parse.sv
rtl/core/klv_queue.sv
rtl/core/klv_ber_stream_framer_unit.sv
bench/klv_ber_stream_framer_unit_tb.sv
